// File: rtl/pcl_pc_pkg.sv
// Package for the PCL page counter: byte codes, field widths and the
// operand word handed from the parser to the page multiplier.
// No dependencies.
package pcl_pc_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 30;
    localparam int DIGIT_W = 4;
    localparam int FF_W    = 32;
    localparam int PAGES_W = 62;
    localparam int TDATA_W = 64;

    // Longest decimal parameter that is collected.
    localparam logic [DIGIT_W-1:0] MAX_DIGITS = 4'd9;

    // Byte codes seen by the parser.
    localparam logic [BYTE_W-1:0] CH_ESC    = 8'd27;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'd12;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LOW_S  = 8'h73;
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_M  = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_LOW_L  = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_UP_W   = 8'h57;
    localparam logic [BYTE_W-1:0] CH_UP_X   = 8'h58;

    // Final counts of one stream, taken by the multiplier stage.
    typedef struct packed {
        logic [FF_W-1:0]  form_feeds;
        logic [NUM_W-1:0] multiplier;
    } pcl_operands_t;

endpackage

// File: rtl/pcl_pc_parser.sv
// Byte-serial PCL escape parser with the form feed and copy counters.
// Depends on pcl_pc_pkg.
module pcl_pc_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,      // parse one byte this cycle
    input  logic [pcl_pc_pkg::BYTE_W-1:0] data_byte,
    input  logic                          last,
    output pcl_pc_pkg::pcl_operands_t     operands   // counts after this byte
);
    import pcl_pc_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ESC   = 4'd1,
        PH_PAREN = 4'd2,
        PH_PSNUM = 4'd3,
        PH_AMP   = 4'd4,
        PH_ALNUM = 4'd5,
        PH_STAR  = 4'd6,
        PH_SBNUM = 4'd7,
        PH_SMNUM = 4'd8,
        PH_SKIP  = 4'd9
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [NUM_W-1:0]    number_reg, number_next;
    logic [DIGIT_W-1:0]  digits_reg, digits_next;
    logic [NUM_W-1:0]    skip_reg, skip_next;
    logic [FF_W-1:0]     ff_reg, ff_next;
    logic [NUM_W-1:0]    mult_reg, mult_next;

    logic                is_digit;
    logic                digit_room;
    logic [NUM_W-1:0]    number_acc;
    logic [NUM_W-1:0]    skip_dec;
    logic                star_ok;
    logic                ff_hit;

    // Small helpers shared by the transitions.
    always_comb
    begin
        is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
        digit_room = digits_reg < MAX_DIGITS;
        number_acc = (number_reg << 3) + (number_reg << 1)
                   + {{(NUM_W-BYTE_W){1'b0}}, data_byte - CH_ZERO};
        skip_dec   = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;
        star_ok    = (phase_reg != PH_STAR) && (phase_reg != PH_SBNUM)
                  && (phase_reg != PH_SMNUM);
    end

    // Next state for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        number_next = number_reg;
        digits_next = digits_reg;
        skip_next   = skip_reg;
        mult_next   = mult_reg;
        ff_hit      = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (data_byte == CH_ESC)
                    phase_next = PH_ESC;
                else
                    ff_hit = (data_byte == CH_FF);
            end
            PH_ESC:
            begin
                if (data_byte == CH_LPAREN || data_byte == CH_RPAREN)
                    phase_next = PH_PAREN;
                else if (data_byte == CH_AMP)
                    phase_next = PH_AMP;
                else if (data_byte == CH_STAR)
                    phase_next = PH_STAR;
                else
                begin
                    ff_hit     = (data_byte == CH_FF);
                    phase_next = PH_IDLE;
                end
            end
            PH_PAREN, PH_AMP, PH_STAR:
            begin
                if (phase_reg == PH_PAREN && data_byte == CH_LOW_S)
                begin
                    number_next = '0;
                    digits_next = '0;
                    phase_next  = PH_PSNUM;
                end
                else if (phase_reg == PH_AMP && data_byte == CH_LOW_L)
                begin
                    number_next = '0;
                    digits_next = '0;
                    phase_next  = PH_ALNUM;
                end
                else if (phase_reg == PH_STAR && data_byte == CH_LOW_B)
                begin
                    number_next = '0;
                    digits_next = '0;
                    phase_next  = PH_SBNUM;
                end
                else if (star_ok && data_byte == CH_STAR)
                    phase_next = PH_STAR;
                else
                begin
                    ff_hit     = (data_byte == CH_FF);
                    phase_next = PH_IDLE;
                end
            end
            PH_PSNUM, PH_ALNUM, PH_SBNUM, PH_SMNUM:
            begin
                if (is_digit)
                begin
                    // An extra digit beyond the limit aborts the escape.
                    if (digit_room)
                    begin
                        number_next = number_acc;
                        digits_next = digits_reg + 1'b1;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                else if (data_byte == CH_UP_W && phase_reg != PH_ALNUM)
                begin
                    skip_next  = number_reg;
                    phase_next = (number_reg != '0) ? PH_SKIP : PH_IDLE;
                end
                else if (data_byte == CH_UP_X && phase_reg == PH_ALNUM)
                begin
                    if (number_reg > NUM_W'(1))
                        mult_next = number_reg;
                    phase_next = PH_IDLE;
                end
                else if (data_byte == CH_LOW_M && phase_reg == PH_SBNUM)
                begin
                    number_next = '0;
                    digits_next = '0;
                    phase_next  = PH_SMNUM;
                end
                else if (star_ok && data_byte == CH_STAR)
                    phase_next = PH_STAR;
                else
                begin
                    ff_hit     = (data_byte == CH_FF);
                    phase_next = PH_IDLE;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Form feed count saturates at its maximum.
        ff_next = (ff_hit && ff_reg != '1) ? ff_reg + 1'b1 : ff_reg;
    end

    assign operands.form_feeds = ff_next;
    assign operands.multiplier = mult_next;

    // Parser state; the last byte of a stream returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            number_reg <= '0;
            digits_reg <= '0;
            skip_reg   <= '0;
            ff_reg     <= '0;
            mult_reg   <= NUM_W'(1);
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg  <= PH_IDLE;
                number_reg <= '0;
                digits_reg <= '0;
                skip_reg   <= '0;
                ff_reg     <= '0;
                mult_reg   <= NUM_W'(1);
            end
            else
            begin
                phase_reg  <= phase_next;
                number_reg <= number_next;
                digits_reg <= digits_next;
                skip_reg   <= skip_next;
                ff_reg     <= ff_next;
                mult_reg   <= mult_next;
            end
        end
    end

endmodule

// File: rtl/pcl_pc_mult.sv
// Operand register, 32 x 30 page multiplier and result register.
// Depends on pcl_pc_pkg.
module pcl_pc_mult (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,       // operands of a finished stream
    input  pcl_pc_pkg::pcl_operands_t      operands,
    output logic                           load_ready, // operand slot can take a word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcl_pc_pkg::TDATA_W-1:0] m_tdata     // [61:0] pages, [63:62] zero
);
    import pcl_pc_pkg::*;

    pcl_operands_t        op_reg;
    logic                 op_valid_reg;
    logic [PAGES_W-1:0]   pages_reg;
    logic                 out_valid_reg;
    logic                 out_ready;
    logic                 op_move;
    logic [PAGES_W-1:0]   product;

    assign out_ready  = !out_valid_reg || m_tready;
    assign op_move    = op_valid_reg && out_ready;
    assign load_ready = !op_valid_reg || out_ready;

    // The full product of 32 by 30 bits fits in the page field.
    assign product = PAGES_W'({{(NUM_W){1'b0}}, op_reg.form_feeds}
                            * {{(FF_W){1'b0}}, op_reg.multiplier});

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_ready)
                op_valid_reg <= load;
            if (out_ready)
                out_valid_reg <= op_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
            op_reg <= operands;
        if (op_move)
            pages_reg <= product;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-PAGES_W){1'b0}}, pages_reg};

endmodule

// File: rtl/pcl_page_counter_unit.sv
// PCL page counter: one byte per cycle in unless stalled, one page total per stream.
// A result passes through the input, operand and result registers in turn.
// Throughput: one byte per cycle unless a last byte waits for a busy operand slot.
// Reset (rst_n, asynchronous, active low) empties all stages, clears the counts and
// sets the copy multiplier to one. Depends on pcl_pc_pkg, pcl_pc_parser, pcl_pc_mult.
module pcl_page_counter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcl_pc_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcl_pc_pkg::TDATA_W-1:0] m_tdata    // [61:0] pages, [63:62] zero
);
    import pcl_pc_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_data_reg;
    logic                in_last_reg;
    logic                in_move;
    logic                load_ready;
    pcl_operands_t       operands;

    // A byte leaves the input register unless it closes a stream and the
    // operand slot is still occupied.
    assign in_move  = in_valid_reg && (!in_last_reg || load_ready);
    assign s_tready = !in_valid_reg || in_move;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pcl_pc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_move),
        .data_byte (in_data_reg),
        .last      (in_last_reg),
        .operands  (operands)
    );

    pcl_pc_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_move && in_last_reg),
        .operands   (operands),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
